@@ rtl/v2r_pkg.sv @@
// ----------------------------------------------------------------------------
// v2r_pkg: shared types and constants for the v210 group to RGB converter
// Holds the pixel type, group geometry and the fixed-point coefficient math.
// ----------------------------------------------------------------------------
package v2r_pkg;

  // Default number of fraction bits of the conversion coefficients.
  localparam int COEF_FRAC_BITS_DEF = 16;

  // One v210 group carries six luma samples and three chroma pairs.
  localparam int PIX_PER_GROUP = 6;
  localparam int LANES         = 3;
  localparam int PIX_IDX_W     = $clog2(PIX_PER_GROUP);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ser_status_t;

  // Coefficients rounded to nearest from their decimal values.
  function automatic longint coef_rv(input int frac_bits);
    return ((longint'(1402) << frac_bits) + 500) / 1000;
  endfunction

  function automatic longint coef_gu(input int frac_bits);
    return ((longint'(34414) << frac_bits) + 50000) / 100000;
  endfunction

  function automatic longint coef_gv(input int frac_bits);
    return ((longint'(71414) << frac_bits) + 50000) / 100000;
  endfunction

  function automatic longint coef_bu(input int frac_bits);
    return ((longint'(1772) << frac_bits) + 500) / 1000;
  endfunction

endpackage

@@ rtl/v2r_if.sv @@
// ----------------------------------------------------------------------------
// v2r interfaces: valid/ready channels of the v210 group to RGB converter
// The group channel carries four v210 words; the pixel channel one RGB pixel.
// ----------------------------------------------------------------------------
interface v2r_group_if;
  logic        valid;
  logic        ready;
  logic [31:0] word_a;
  logic [31:0] word_b;
  logic [31:0] word_c;
  logic [31:0] word_d;

  modport source (output valid, output word_a, output word_b, output word_c,
                  output word_d, input ready);
  modport sink (input valid, input word_a, input word_b, input word_c,
                input word_d, output ready);
endinterface

interface v2r_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last;

  modport source (output valid, output red, output green, output blue,
                  output last, input ready);
  modport sink (input valid, input red, input green, input blue,
                input last, output ready);
endinterface

@@ rtl/v2r_lane.sv @@
// ----------------------------------------------------------------------------
// v2r_lane: color conversion lane for one chroma pair and its two luma samples
// Registers the chroma products, then forms, floors and clamps both pixels.
// ----------------------------------------------------------------------------
module v2r_lane import v2r_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       prod_en,
  input  logic       pix_en,
  input  logic [7:0] y_even,
  input  logic [7:0] y_odd,
  input  logic [7:0] u,
  input  logic [7:0] v,
  output rgb_t       pix_even,
  output rgb_t       pix_odd
);

  localparam int COEF_W = COEF_FRAC_BITS + 2;
  localparam int PROD_W = COEF_W + 8;
  localparam int ACC_W  = COEF_FRAC_BITS + 12;

  localparam logic signed [COEF_W-1:0] K_RV = COEF_W'(coef_rv(COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] K_GU = COEF_W'(coef_gu(COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] K_GV = COEF_W'(coef_gv(COEF_FRAC_BITS));
  localparam logic signed [COEF_W-1:0] K_BU = COEF_W'(coef_bu(COEF_FRAC_BITS));

  // Chroma offset by 128 is the sample with its top bit inverted, read signed.
  logic signed [7:0] d;
  logic signed [7:0] e;

  logic signed [PROD_W-1:0] prod_rv;
  logic signed [PROD_W-1:0] prod_gu;
  logic signed [PROD_W-1:0] prod_gv;
  logic signed [PROD_W-1:0] prod_bu;
  logic [7:0]               y_even_q;
  logic [7:0]               y_odd_q;

  logic signed [ACC_W-1:0] term_r;
  logic signed [ACC_W-1:0] term_g;
  logic signed [ACC_W-1:0] term_b;
  logic signed [ACC_W-1:0] base_even;
  logic signed [ACC_W-1:0] base_odd;
  rgb_t                    pix_even_next;
  rgb_t                    pix_odd_next;

  function automatic logic [7:0] to_byte(input logic signed [ACC_W-1:0] acc);
    logic [7:0] res;
    if (acc[ACC_W-1]) begin
      res = 8'd0;
    end else if (|acc[ACC_W-2:COEF_FRAC_BITS+8]) begin
      res = 8'hFF;
    end else begin
      res = acc[COEF_FRAC_BITS+7:COEF_FRAC_BITS];
    end
    return res;
  endfunction

  assign d = {~u[7], u[6:0]};
  assign e = {~v[7], v[6:0]};

  always_ff @(posedge clk) begin
    if (prod_en) begin
      prod_rv  <= PROD_W'(K_RV) * PROD_W'(e);
      prod_gu  <= PROD_W'(K_GU) * PROD_W'(d);
      prod_gv  <= PROD_W'(K_GV) * PROD_W'(e);
      prod_bu  <= PROD_W'(K_BU) * PROD_W'(d);
      y_even_q <= y_even;
      y_odd_q  <= y_odd;
    end
  end

  always_comb begin
    term_r    = ACC_W'(prod_rv);
    term_g    = -ACC_W'(prod_gu) - ACC_W'(prod_gv);
    term_b    = ACC_W'(prod_bu);
    base_even = $signed(ACC_W'({y_even_q, {COEF_FRAC_BITS{1'b0}}}));
    base_odd  = $signed(ACC_W'({y_odd_q, {COEF_FRAC_BITS{1'b0}}}));

    pix_even_next.red   = to_byte(base_even + term_r);
    pix_even_next.green = to_byte(base_even + term_g);
    pix_even_next.blue  = to_byte(base_even + term_b);
    pix_odd_next.red    = to_byte(base_odd + term_r);
    pix_odd_next.green  = to_byte(base_odd + term_g);
    pix_odd_next.blue   = to_byte(base_odd + term_b);
  end

  always_ff @(posedge clk) begin
    if (pix_en) begin
      pix_even <= pix_even_next;
      pix_odd  <= pix_odd_next;
    end
  end

endmodule

@@ rtl/v2r_serializer.sv @@
// ----------------------------------------------------------------------------
// v2r_serializer: merges the lane results into a stream of pixels
// Holds the six pixels of one group and sends them one per transaction.
// ----------------------------------------------------------------------------
module v2r_serializer import v2r_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         load,
  input  rgb_t [PIX_PER_GROUP-1:0]     pixels,
  output ser_status_t                  status,
  v2r_pixel_if.source                  pixel
);

  localparam logic [PIX_IDX_W-1:0] LAST_IDX = PIX_IDX_W'(PIX_PER_GROUP - 1);

  logic                        busy;
  logic [PIX_IDX_W-1:0]        cnt;
  rgb_t [PIX_PER_GROUP-1:0]    pix_buf;
  rgb_t                        sel_pix;

  assign status.busy = busy;
  assign status.done = busy && pixel.ready && (cnt == LAST_IDX);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      cnt  <= '0;
    end else if (busy && pixel.ready) begin
      if (cnt == LAST_IDX) begin
        busy <= 1'b0;
        cnt  <= '0;
      end else begin
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pix_buf <= pixels;
    end
  end

  assign sel_pix     = pix_buf[cnt];
  assign pixel.valid = busy;
  assign pixel.red   = sel_pix.red;
  assign pixel.green = sel_pix.green;
  assign pixel.blue  = sel_pix.blue;
  assign pixel.last  = (cnt == LAST_IDX);

`ifndef SYNTH
  // A group in progress keeps presenting pixels until its last one is taken.
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    pixel.valid && pixel.ready && !pixel.last |=> pixel.valid)
    else $error("group ended before its last pixel");

  // A new group is only loaded once the previous one is fully sent.
  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> !busy || (pixel.ready && pixel.last))
    else $error("group loaded over one still being sent");

  // A stalled pixel keeps its place in the group.
  a_hold_cnt: assert property (@(posedge clk) disable iff (rst)
    busy && !pixel.ready |=> $stable(cnt) && busy)
    else $error("pixel index moved during a stall");
`endif

endmodule

@@ rtl/v210_group_to_rgb_top.sv @@
// ----------------------------------------------------------------------------
// v210_group_to_rgb_top: v210 group to full-range BT.601 RGB converter
// Unpacks one v210 group and streams out its six RGB pixels.
// ----------------------------------------------------------------------------
// Usage: the grp channel takes one v210 group (four 32-bit words, bits 31:30
// ignored) per transaction; the pixel channel gives six RGB pixels per group,
// in luma order, with last set on the sixth. Samples are cut to 8 bits and
// converted with Q-format coefficients, floored and clamped to 0..255.
// Three lanes, one per chroma pair, each convert two pixels. A lane has two
// register stages: the chroma products, then the clamped pixels. A group
// accepted on grp passes the product registers, the pixel registers and the
// serializer buffer, in that order, before its first pixel is presented.
// The output port moves one pixel per cycle while the receiver is ready; the
// next group is taken and converted while the current one is still being sent,
// and waits in the lane registers.
// When the receiver stalls, the current pixel holds, the lane stages fill up
// and grp.ready falls. Reset empties all stages and drops any pending group.
// ----------------------------------------------------------------------------
module v210_group_to_rgb_top import v2r_pkg::*; #(
  parameter int COEF_FRAC_BITS = COEF_FRAC_BITS_DEF
) (
  input logic         clk,
  input logic         rst,
  v2r_group_if.sink   grp,
  v2r_pixel_if.source pixel
);

  // Stage occupancy: products held in the lanes, and converted pixels held.
  logic        prod_valid;
  logic        pix_valid;
  logic        prod_en;
  logic        pix_en;
  logic        pix_load;
  ser_status_t ser_status;

  logic [7:0] y_samp  [PIX_PER_GROUP];
  logic [7:0] cb_samp [LANES];
  logic [7:0] cr_samp [LANES];

  rgb_t [PIX_PER_GROUP-1:0] lane_pix;

  // The serializer takes a new group when empty or as its last pixel leaves.
  assign pix_load  = pix_valid && (!ser_status.busy || ser_status.done);
  assign pix_en    = prod_valid && (!pix_valid || pix_load);
  assign grp.ready = !prod_valid || pix_en;
  assign prod_en   = grp.valid && grp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      prod_valid <= 1'b0;
      pix_valid  <= 1'b0;
    end else begin
      if (prod_en) begin
        prod_valid <= 1'b1;
      end else if (pix_en) begin
        prod_valid <= 1'b0;
      end
      if (pix_en) begin
        pix_valid <= 1'b1;
      end else if (pix_load) begin
        pix_valid <= 1'b0;
      end
    end
  end

  // Each sample keeps its top eight of ten bits.
  always_comb begin
    cb_samp[0] = grp.word_a[9:2];
    y_samp[0]  = grp.word_a[19:12];
    cr_samp[0] = grp.word_a[29:22];
    y_samp[1]  = grp.word_b[9:2];
    cb_samp[1] = grp.word_b[19:12];
    y_samp[2]  = grp.word_b[29:22];
    cr_samp[1] = grp.word_c[9:2];
    y_samp[3]  = grp.word_c[19:12];
    cb_samp[2] = grp.word_c[29:22];
    y_samp[4]  = grp.word_d[9:2];
    cr_samp[2] = grp.word_d[19:12];
    y_samp[5]  = grp.word_d[29:22];
  end

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    v2r_lane #(
      .COEF_FRAC_BITS(COEF_FRAC_BITS)
    ) u_lane (
      .clk     (clk),
      .prod_en (prod_en),
      .pix_en  (pix_en),
      .y_even  (y_samp[2*i]),
      .y_odd   (y_samp[2*i+1]),
      .u       (cb_samp[i]),
      .v       (cr_samp[i]),
      .pix_even(lane_pix[2*i]),
      .pix_odd (lane_pix[2*i+1])
    );
  end

  v2r_serializer u_ser (
    .clk   (clk),
    .rst   (rst),
    .load  (pix_load),
    .pixels(lane_pix),
    .status(ser_status),
    .pixel (pixel)
  );

`ifndef SYNTH
  // An accepted group always occupies the product stage on the next cycle.
  a_grp_held: assert property (@(posedge clk) disable iff (rst)
    grp.valid && grp.ready |=> prod_valid)
    else $error("accepted group lost before the product stage");

  // Converted pixels only move on into a free or finishing serializer.
  a_pix_move: assert property (@(posedge clk) disable iff (rst)
    pix_valid && ser_status.busy && !ser_status.done |=> pix_valid)
    else $error("converted group dropped while serializer busy");

  // The product stage never advances into a full, stuck pixel stage.
  a_prod_hold: assert property (@(posedge clk) disable iff (rst)
    prod_valid && pix_valid && !pix_load |-> !grp.ready)
    else $error("group accepted while pipeline is blocked");
`endif

endmodule
